// File: sv/nsc_pkg.sv
// shared types, constants and helpers for the nmea sentence checker
package nsc_pkg;

    localparam int BUFFER_SIZE_DEF = 96;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] TYPE_LETTER_RST = 8'h52;

    localparam logic [4:0] HEX_BAD = 5'd16;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_STAR = 2'd1;
    localparam logic [1:0] ST_BAD_HEX = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    localparam logic [1:0] REG_TYPE_LETTER_ADDR = 2'd0;

    // what the front hands over for each line feed
    typedef struct packed {
        logic [6:0] len;
        logic       long_enough;
        logic       star;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] xr;
    } nsc_rec_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        begin
            if (c inside {[8'h30:8'h39]})
            begin
                v = 5'(c - 8'h30);
            end
            else if (c inside {[8'h41:8'h46]})
            begin
                v = 5'(c - 8'h41 + 8'd10);
            end
            else if (c inside {[8'h61:8'h66]})
            begin
                v = 5'(c - 8'h61 + 8'd10);
            end
            else
            begin
                v = HEX_BAD;
            end
            return v;
        end
    endfunction

endpackage

// File: sv/nsc_front.sv
// framing front: takes bytes, tracks position, xor and history, queues a record per line feed
module nsc_front
    import nsc_pkg::*;
#(
    parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic [7:0] type_letter,
    input  logic       q_full,
    output logic       push,
    output nsc_rec_t   rec
);

    localparam int PW = $clog2(BUFFER_SIZE);
    localparam logic [PW-1:0] LAST_POS = PW'(BUFFER_SIZE - 1);

    logic [PW-1:0] pos_reg, pos_next;
    logic          fid_reg, fid_next;
    logic [7:0]    xor_reg, xor_next;
    logic [7:0]    r0_reg, r0_next;
    logic [7:0]    r1_reg, r1_next;
    logic [7:0]    r2_reg, r2_next;
    logic          star_reg, star_next;

    logic          accept;
    logic          restart;
    logic [PW-1:0] p;
    logic          fid_e;
    logic [7:0]    xr_e;
    logic [7:0]    r0_e;
    logic [7:0]    r1_e;
    logic [7:0]    r2_e;
    logic          star_e;
    logic          drop;
    logic          lf;
    logic [PW+6:0] p_ext;

    assign in_stall = q_full;
    assign accept = in_valid && !q_full;

    // overflow and index 0 both start from a clean frame
    assign restart = (pos_reg >= LAST_POS) || (pos_reg == '0);
    assign p = (pos_reg >= LAST_POS) ? '0 : pos_reg;
    assign fid_e = restart ? (rx_byte == CH_DOLLAR) : fid_reg;
    assign xr_e = restart ? 8'h00 : xor_reg;
    assign r0_e = restart ? 8'h00 : r0_reg;
    assign r1_e = restart ? 8'h00 : r1_reg;
    assign r2_e = restart ? 8'h00 : r2_reg;
    assign star_e = restart ? 1'b0 : star_reg;

    assign drop = (p == PW'(3)) && (!fid_e || (rx_byte != type_letter));
    assign lf = !drop && (rx_byte == CH_LF);

    assign p_ext = (PW + 7)'(p);

    assign push = accept && lf;
    assign rec.len = p_ext[6:0];
    assign rec.long_enough = (p >= PW'(5));
    assign rec.star = star_e;
    assign rec.hi = r2_e;
    assign rec.lo = r1_e;
    assign rec.xr = xr_e;

    always_comb
    begin
        pos_next = pos_reg;
        fid_next = fid_reg;
        xor_next = xor_reg;
        r0_next = r0_reg;
        r1_next = r1_reg;
        r2_next = r2_reg;
        star_next = star_reg;
        if (accept)
        begin
            if (drop || lf)
            begin
                pos_next = '0;
                fid_next = 1'b0;
                xor_next = 8'h00;
                r0_next = 8'h00;
                r1_next = 8'h00;
                r2_next = 8'h00;
                star_next = 1'b0;
            end
            else
            begin
                // from index 4 on the oldest history byte joins the xor
                if (p >= PW'(4))
                begin
                    xor_next = xr_e ^ r2_e;
                    star_next = (r2_e == CH_STAR);
                end
                else
                begin
                    xor_next = xr_e;
                    star_next = star_e;
                end
                r2_next = r1_e;
                r1_next = r0_e;
                r0_next = rx_byte;
                fid_next = fid_e;
                pos_next = p + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            fid_reg <= 1'b0;
            xor_reg <= 8'h00;
            r0_reg <= 8'h00;
            r1_reg <= 8'h00;
            r2_reg <= 8'h00;
            star_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            fid_reg <= fid_next;
            xor_reg <= xor_next;
            r0_reg <= r0_next;
            r1_reg <= r1_next;
            r2_reg <= r2_next;
            star_reg <= star_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("position ran past the buffer");

endmodule

// File: sv/nsc_queue.sv
// short record queue between framing front and checksum back
module nsc_queue
    import nsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  nsc_rec_t rec_in,
    output logic     full,
    output logic     head_valid,
    output nsc_rec_t head,
    input  logic     pop
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    nsc_rec_t      entry_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= rec_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("record pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("record popped from an empty queue");

endmodule

// File: sv/nsc_back.sv
// checksum back: decodes hex digits, compares sums, holds the result item
module nsc_back
    import nsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  nsc_rec_t   q_rec,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [6:0] sentence_length,
    output logic [7:0] computed_sum,
    output logic [7:0] received_sum
);

    logic       valid_reg, valid_next;
    logic [1:0] status_reg;
    logic [6:0] len_reg;
    logic [7:0] comp_reg;
    logic [7:0] recv_reg;

    logic [4:0] hi_val;
    logic [4:0] lo_val;
    logic [7:0] digits;
    logic [1:0] st_c;
    logic [7:0] comp_c;
    logic [7:0] recv_c;

    assign pop = q_valid && (!valid_reg || !out_stall);

    assign hi_val = hex_value(q_rec.hi);
    assign lo_val = hex_value(q_rec.lo);
    assign digits = {hi_val[3:0], lo_val[3:0]};

    always_comb
    begin
        st_c = ST_NO_STAR;
        comp_c = 8'h00;
        recv_c = 8'h00;
        if (q_rec.long_enough && q_rec.star)
        begin
            // the star itself was folded into the xor on its way out
            comp_c = q_rec.xr ^ CH_STAR;
            if ((hi_val == HEX_BAD) || (lo_val == HEX_BAD))
            begin
                st_c = ST_BAD_HEX;
            end
            else
            begin
                recv_c = digits;
                st_c = (digits == comp_c) ? ST_OK : ST_MISMATCH;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= st_c;
            len_reg <= q_rec.len;
            comp_reg <= comp_c;
            recv_reg <= recv_c;
        end
    end

    assign out_valid = valid_reg;
    assign status = status_reg;
    assign sentence_length = len_reg;
    assign computed_sum = comp_reg;
    assign received_sum = recv_reg;

    a_ok_sums_match: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (status_reg == ST_OK)) |-> (comp_reg == recv_reg))
        else $error("valid status with differing sums");

    a_no_star_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (status_reg == ST_NO_STAR)) |-> ((comp_reg == 8'h00) && (recv_reg == 8'h00)))
        else $error("no-star item carries nonzero sums");

endmodule

// File: sv/nmea_sentence_checker.sv
// top level of the nmea sentence checker: config register, front, queue and back
//
// rx_byte comes in on in_valid/in_stall, one item per cycle when not stalled.
// bytes are framed into sentences; '$' at index 0 and the type letter at
// index 3 admit a sentence, otherwise it is dropped at index 3 with no result.
// a line feed closes the sentence and yields one result item on
// out_valid/out_stall: status, sentence_length, computed_sum, received_sum.
// the line feed's record is written into the queue and then popped into the
// output register that drives out_valid; throughput is one byte per cycle
// while in_stall is low, as the front updates its framing state per byte.
// a two-entry record queue sits between framing and checksum evaluation;
// when the receiver stalls, the output register holds its item, the queue
// fills, and in_stall rises only once the queue is full.
// reset clears framing state and the queue, and sets type_letter to 'R'; the
// user writes type_letter on the apb port (any paddr) only while idle, unchecked.
module nmea_sentence_checker
    import nsc_pkg::*;
#(
    parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [6:0]  sentence_length,
    output logic [7:0]  computed_sum,
    output logic [7:0]  received_sum,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] type_letter_reg;
    logic       q_full;
    logic       push;
    nsc_rec_t   rec;
    logic       q_valid;
    nsc_rec_t   q_rec;
    logic       pop;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TYPE_LETTER_ADDR) ? {24'h000000, type_letter_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_letter_reg <= TYPE_LETTER_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            type_letter_reg <= pwdata[7:0];
        end
    end

    nsc_front #(
        .BUFFER_SIZE(BUFFER_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .type_letter(type_letter_reg),
        .q_full     (q_full),
        .push       (push),
        .rec        (rec)
    );

    nsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rec_in    (rec),
        .full      (q_full),
        .head_valid(q_valid),
        .head      (q_rec),
        .pop       (pop)
    );

    nsc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_rec          (q_rec),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .sentence_length(sentence_length),
        .computed_sum   (computed_sum),
        .received_sum   (received_sum)
    );

endmodule

// File: tb/nmea_sentence_checker_test.sv
// self-checking testbench for the nmea sentence checker
`timescale 1ns / 100ps

module nmea_sentence_checker_test
    import nsc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_SHOWN = 10;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef enum int
    {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_HEX_HI,
        FLAW_HEX_LO,
        FLAW_NO_STAR,
        FLAW_TYPE,
        FLAW_DOLLAR
    } flaw_t;

    typedef struct packed
    {
        logic [1:0] status;
        logic [6:0] len;
        logic [7:0] comp;
        logic [7:0] recv;
    } sentence_report_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [6:0]  sentence_length;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = 2'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [7:0] cfg_type;
    int         pos;
    bit         saw_dollar;
    logic [7:0] xor_acc;
    logic [7:0] hist [3];
    bit         star_left;

    sentence_report_t expected_reports [$];
    logic [7:0]       line_buf [$];

    int  mismatches = 0;
    int  bytes_accepted = 0;
    int  reports_predicted = 0;
    int  idle_cycles = 0;
    bit  idle_on = 1'b0;
    bit  stall_on = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_active = 1'b0;

    nmea_sentence_checker u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .sentence_length (sentence_length),
        .computed_sum    (computed_sum),
        .received_sum    (received_sum),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b0, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            return 5'({1'b0, c[3:0]} + 5'd9);
        end
        return HEX_BAD;
    endfunction

    function automatic void clear_frame();
        pos = 0;
        saw_dollar = 1'b0;
        xor_acc = 8'h00;
        hist[0] = 8'h00;
        hist[1] = 8'h00;
        hist[2] = 8'h00;
        star_left = 1'b0;
    endfunction

    // advances the framing state by one byte; returns 1 when a report is due
    function automatic bit frame_byte(input logic [7:0] b, output sentence_report_t rep);
        int p;
        logic [4:0] hi;
        logic [4:0] lo;
        rep = '0;
        if (pos >= BUFFER_SIZE_DEF - 1)
        begin
            clear_frame();
        end
        p = pos;
        if (p == 0)
        begin
            clear_frame();
            saw_dollar = (b == CH_DOLLAR);
        end
        if (p == 3 && (!saw_dollar || b != cfg_type))
        begin
            clear_frame();
            return 1'b0;
        end
        if (b == CH_LF)
        begin
            rep.status = ST_NO_STAR;
            rep.len = 7'(p);
            if (p >= 5 && star_left)
            begin
                rep.comp = xor_acc ^ CH_STAR;
                hi = nibble_of(hist[2]);
                lo = nibble_of(hist[1]);
                if (hi == HEX_BAD || lo == HEX_BAD)
                begin
                    rep.status = ST_BAD_HEX;
                end
                else
                begin
                    rep.recv = {hi[3:0], lo[3:0]};
                    rep.status = (rep.recv == rep.comp) ? ST_OK : ST_MISMATCH;
                end
            end
            clear_frame();
            return 1'b1;
        end
        if (p >= 4)
        begin
            xor_acc = xor_acc ^ hist[2];
            star_left = (hist[2] == CH_STAR);
        end
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = b;
        pos = p + 1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return CH_ZERO + 8'(n);
        end
        return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] payload_byte();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do
        begin
            c = payload_byte();
        end
        while (nibble_of(c) != HEX_BAD);
        return c;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
        begin
            $display("%s", msg);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        sentence_report_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                note_mismatch($sformatf(
                    "unexpected result: status %0d len %0d comp %02h recv %02h",
                    status, sentence_length, computed_sum, received_sum));
            end
            else
            begin
                exp = expected_reports.pop_front();
                if (status != exp.status || sentence_length != exp.len
                    || computed_sum != exp.comp || received_sum != exp.recv)
                begin
                    note_mismatch($sformatf({
                        "mismatch: expected status %0d len %0d comp %02h recv %02h, ",
                        "got status %0d len %0d comp %02h recv %02h"},
                        exp.status, exp.len, exp.comp, exp.recv,
                        status, sentence_length, computed_sum, received_sum));
                end
            end
        end
    end

    // receiver stall: random bursts, plus one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_active = 1'b0;
                hold_req = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("nmea_sentence_checker_test failed");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        sentence_report_t rep;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        bytes_accepted++;
        if (frame_byte(b, rep))
        begin
            expected_reports.push_back(rep);
            reports_predicted++;
        end
    endtask

    task automatic send_line();
        foreach (line_buf[i])
        begin
            send_byte(line_buf[i]);
        end
    endtask

    task automatic build_sentence(input int body_len, input flaw_t flaw);
        logic [7:0] sum;
        logic [7:0] sent_sum;
        bit lower;
        line_buf.delete();
        if (flaw == FLAW_DOLLAR)
        begin
            line_buf.push_back(CH_DOLLAR ^ 8'(1 << $urandom_range(0, 7)));
        end
        else
        begin
            line_buf.push_back(CH_DOLLAR);
        end
        line_buf.push_back(payload_byte());
        line_buf.push_back(payload_byte());
        if (flaw == FLAW_TYPE)
        begin
            line_buf.push_back(cfg_type ^ 8'(1 << $urandom_range(0, 7)));
        end
        else
        begin
            line_buf.push_back(cfg_type);
        end
        repeat (body_len) line_buf.push_back(payload_byte());
        sum = 8'h00;
        for (int i = 1; i < line_buf.size(); i++)
        begin
            sum ^= line_buf[i];
        end
        if (flaw == FLAW_NO_STAR)
        begin
            line_buf.push_back(payload_byte());
        end
        else
        begin
            line_buf.push_back(CH_STAR);
        end
        sent_sum = (flaw == FLAW_SUM) ? sum ^ 8'(1 << $urandom_range(0, 7)) : sum;
        lower = 1'($urandom_range(0, 1));
        line_buf.push_back((flaw == FLAW_HEX_HI) ? non_hex_byte() : hex_char(sent_sum[7:4], lower));
        line_buf.push_back((flaw == FLAW_HEX_LO) ? non_hex_byte() : hex_char(sent_sum[3:0], lower));
        line_buf.push_back(($urandom_range(0, 3) == 0) ? payload_byte() : CH_CR);
        line_buf.push_back(CH_LF);
    endtask

    task automatic send_sentence(input int body_len, input flaw_t flaw);
        build_sentence(body_len, flaw);
        send_line();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12))
        begin
            send_byte(($urandom_range(0, 3) == 0) ? CH_LF : 8'($urandom_range(0, 255)));
        end
    endtask

    // sender pauses until every expected result is back, then lets the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_type_letter(input logic [7:0] value);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_TYPE_LETTER_ADDR;
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_type = value;
    endtask

    task automatic test_short_lines();
        line_buf = '{CH_LF};
        send_line();
        line_buf = '{CH_DOLLAR, CH_LF};
        send_line();
        line_buf = '{CH_DOLLAR, 8'h47, CH_LF};
        send_line();
        // line feed at index 3 fails the type test and is dropped
        line_buf = '{CH_DOLLAR, 8'h47, 8'h50, CH_LF};
        send_line();
        line_buf = '{CH_DOLLAR, 8'h47, 8'h50, cfg_type, CH_LF};
        send_line();
    endtask

    task automatic test_checksums();
        send_sentence(3, FLAW_NONE);
        send_sentence(0, FLAW_NONE);
        send_sentence(5, FLAW_SUM);
        send_sentence(4, FLAW_HEX_HI);
        send_sentence(4, FLAW_HEX_LO);
        send_sentence(6, FLAW_NO_STAR);
        send_sentence(2, FLAW_TYPE);
        send_sentence(2, FLAW_DOLLAR);
        line_buf = '{CH_DOLLAR, 8'hFF, 8'h00, cfg_type, 8'hFF, 8'h00,
                     CH_STAR, 8'h66, 8'h66, CH_CR, CH_LF};
        send_line();
    endtask

    task automatic test_overflow();
        // longest sentence that still fits, then one byte too long
        send_sentence(BUFFER_SIZE_DEF - 10, FLAW_NONE);
        send_sentence(BUFFER_SIZE_DEF - 9, FLAW_NONE);
    endtask

    task automatic test_type_letter();
        write_type_letter(8'h00);
        send_sentence(3, FLAW_NONE);
        send_sentence(3, FLAW_TYPE);
        write_type_letter(8'hFF);
        send_sentence(2, FLAW_NONE);
        write_type_letter(CH_LF);
        // type letter equal to line feed: line ends at index 3
        line_buf = '{CH_DOLLAR, 8'h41, 8'h42, CH_LF};
        send_line();
        write_type_letter(CH_ZERO);
        // shortest checked line: star at index 1
        line_buf = '{CH_DOLLAR, CH_STAR, CH_ZERO, CH_ZERO, CH_CR, CH_LF};
        send_line();
        write_type_letter(TYPE_LETTER_RST);
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_req = 1'b1;
        while (!hold_active)
        begin
            @(posedge clk);
        end
        repeat (5)
        begin
            line_buf = '{CH_DOLLAR, payload_byte(), payload_byte(), cfg_type, CH_LF};
            send_line();
        end
        wait_idle();
    endtask

    task automatic random_sentence();
        int r;
        int body_len;
        r = $urandom_range(0, 99);
        body_len = $urandom_range(0, 10);
        if (r < 55)
        begin
            send_sentence(body_len, FLAW_NONE);
        end
        else if (r < 65)
        begin
            send_sentence(body_len, FLAW_SUM);
        end
        else if (r < 70)
        begin
            send_sentence(body_len, FLAW_HEX_HI);
        end
        else if (r < 75)
        begin
            send_sentence(body_len, FLAW_HEX_LO);
        end
        else if (r < 80)
        begin
            send_sentence(body_len, FLAW_NO_STAR);
        end
        else if (r < 85)
        begin
            send_sentence(body_len, FLAW_TYPE);
        end
        else if (r < 88)
        begin
            send_sentence(body_len, FLAW_DOLLAR);
        end
        else
        begin
            send_noise();
        end
    endtask

    task automatic test_random(input int byte_goal, input int report_goal);
        int b0;
        int r0;
        b0 = bytes_accepted;
        r0 = reports_predicted;
        while (bytes_accepted - b0 < byte_goal || reports_predicted - r0 < report_goal)
        begin
            random_sentence();
        end
    endtask

    initial
    begin
        cfg_type = TYPE_LETTER_RST;
        clear_frame();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_lines();
        test_checksums();
        idle_on = 1'b1;
        stall_on = 1'b1;
        test_overflow();
        test_type_letter();
        test_backpressure();
        test_random(24, 3);
        write_type_letter(8'($urandom_range(0, 255)));
        test_random(12, 2);
        write_type_letter(TYPE_LETTER_RST);
        test_random(12, 2);
        idle_on = 1'b0;
        stall_on = 1'b0;
        test_random(20, 3);

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
        begin
            $display("nmea_sentence_checker_test passed");
        end
        else
        begin
            $display("nmea_sentence_checker_test failed");
        end
        $finish;
    end

endmodule
